@@ design/fifo_fed_burst_pulse_generator_defines.svh @@
// ----------------------------------------------------------------------------
// Burst pulse generator: assertion macros
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef FIFO_FED_BURST_PULSE_GENERATOR_DEFINES_SVH
`define FIFO_FED_BURST_PULSE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FFBPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FFBPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ffbpg_pkg.sv @@
// ----------------------------------------------------------------------------
// ffbpg_pkg
// Types and fixed constants of the burst pulse generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffbpg_pkg;

    // Field widths
    localparam int REQ_W   = 3;
    localparam int WORD_W  = 32;
    localparam int HALF_W  = 16;
    localparam int CYC_W   = 33;
    localparam int LEVEL_W = 3;
    localparam int S_DATA_W = 40;   // word + enable, padded to bytes
    localparam int M_DATA_W = 8;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ENABLE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REINIT = 3'd4;

    // Register map (index is paddr[2])
    localparam logic REG_HALF_PERIOD = 1'b0;

    // Half period: reset value and shortest usable value
    localparam logic [HALF_W-1:0] HALF_RESET = 16'd25;
    localparam logic [HALF_W-1:0] HALF_MIN   = 16'd2;

    // Queue control, one action per word at most
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_ctrl_t;

endpackage

@@ design/ffbpg_fifo.sv @@
// ----------------------------------------------------------------------------
// ffbpg_fifo
// Small circular queue of burst words with head read-out and fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffbpg_fifo #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ffbpg_pkg::fifo_ctrl_t                 ctrl,
    input  logic [ffbpg_pkg::WORD_W-1:0]          wr_data,
    output logic [ffbpg_pkg::WORD_W-1:0]          head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count_next
);
    import ffbpg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH-1);

    logic [WORD_W-1:0] store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, cnt_next;

    // Pointer and count update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = count_reg;
        if (ctrl.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            cnt_next    = '0;
        end
        else if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            cnt_next    = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next    = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= cnt_next;
        end
    end

    // Word storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
            store_reg[wr_ptr_reg] <= wr_data;
    end

    assign head       = store_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign count_next = cnt_next;

endmodule

@@ design/fifo_fed_burst_pulse_generator.sv @@
// The status word of an accepted input word appears on m_tdata in the next cycle.
// Throughput: one word per cycle while m_tready is high; the output register refills as it drains.
// The widest arithmetic is the tick update: a 33-bit burst count load/decrement.
// Reset (rst_n low, asynchronous): queue empty, no burst, pin low, disabled,
// half period back to 25 ticks, output empty.
// ----------------------------------------------------------------------------
// fifo_fed_burst_pulse_generator
// Square-wave burst generator fed from a word queue, with APB half period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_fed_burst_pulse_generator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ffbpg_pkg::ADDR_W-1:0]        paddr,
    input  logic [ffbpg_pkg::APB_W-1:0]         pwdata,
    output logic [ffbpg_pkg::APB_W-1:0]         prdata,
    output logic                                pready,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] push_word, [32] enable_value, [39:33] zero
    input  logic [ffbpg_pkg::S_DATA_W-1:0]      s_tdata,
    // [2:0] req_type
    input  logic [ffbpg_pkg::REQ_W-1:0]         s_tuser,
    // Status stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] pin_level, [1] pin_edge, [2] push_accepted, [3] fifo_full,
    // [6:4] fifo_level, [7] burst_active
    output logic [ffbpg_pkg::M_DATA_W-1:0]      m_tdata
);
    import ffbpg_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Configuration
    logic [HALF_W-1:0] half_reg;
    logic [HALF_W-1:0] half_eff;
    logic              cfg_wr;

    // Pulse state
    logic [CYC_W-1:0]  cyc_reg, cyc_next;
    logic [HALF_W-1:0] cd_reg, cd_next;
    logic              level_reg, level_next;
    logic              run_en_reg, run_en_next;

    // Tick temporaries
    logic [CYC_W-1:0]  cyc_load;
    logic [HALF_W-1:0] cd_cur;
    logic              accepted;

    // Queue interface
    fifo_ctrl_t        fifo_ctrl;
    logic [WORD_W-1:0] fifo_head;
    logic [CNT_W-1:0]  q_level;
    logic [CNT_W-1:0]  q_level_next;

    // Stream side
    logic              accept;
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [REQ_W-1:0]  req;
    logic [WORD_W-1:0] word_in;
    logic              en_in;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HALF_PERIOD);
    assign prdata = (paddr[2] == REG_HALF_PERIOD) ? APB_W'(half_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= HALF_RESET;
        else if (cfg_wr)
            half_reg <= pwdata[HALF_W-1:0];
    end

    assign half_eff = (half_reg < HALF_MIN) ? HALF_MIN : half_reg;

    // Handshake: take a word whenever the output slot is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign req     = s_tuser;
    assign word_in = s_tdata[WORD_W-1:0];
    assign en_in   = s_tdata[WORD_W];

    // Word queue
    ffbpg_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fifo_ctrl),
        .wr_data    (word_in),
        .head       (fifo_head),
        .count      (q_level),
        .count_next (q_level_next)
    );

    // Request decode and pulse state update
    always_comb
    begin
        cyc_next    = cyc_reg;
        cd_next     = cd_reg;
        level_next  = level_reg;
        run_en_next = run_en_reg;
        fifo_ctrl   = '0;
        accepted    = 1'b0;
        cyc_load    = cyc_reg;
        cd_cur      = cd_reg;
        if (accept)
        begin
            case (req)
                REQ_TICK:
                begin
                    if (run_en_reg && ((cyc_reg != '0) || (q_level != '0)))
                    begin
                        // idle with a word waiting: pop it, edge is due now
                        if (cyc_reg == '0)
                        begin
                            fifo_ctrl.pop = 1'b1;
                            cyc_load      = {1'b0, fifo_head} + 1'b1;
                            cd_cur        = '0;
                        end
                        if (cd_cur > 16'd1)
                        begin
                            cd_next  = cd_cur - 1'b1;
                            cyc_next = cyc_load;
                        end
                        else
                        begin
                            cd_next    = (cd_cur == '0) ? half_eff - 1'b1 : half_eff;
                            level_next = !level_reg;
                            // a falling edge closes one cycle
                            cyc_next   = (!level_next && (cyc_load != '0))
                                         ? cyc_load - 1'b1 : cyc_load;
                        end
                    end
                end
                REQ_PUSH:
                begin
                    if (q_level < CNT_FULL)
                    begin
                        fifo_ctrl.push = 1'b1;
                        accepted       = 1'b1;
                    end
                end
                REQ_ENABLE:
                begin
                    run_en_next = en_in;
                    if (!en_in)
                    begin
                        cyc_next        = '0;
                        level_next      = 1'b0;
                        fifo_ctrl.clear = 1'b1;
                    end
                end
                REQ_CLEAR:
                begin
                    fifo_ctrl.clear = 1'b1;
                end
                REQ_REINIT:
                begin
                    cyc_next        = '0;
                    level_next      = 1'b0;
                    cd_next         = half_eff;
                    fifo_ctrl.clear = 1'b1;
                end
                default:
                begin
                    // unused codes only report status
                end
            endcase
        end
    end

    // Status word for this request
    always_comb
    begin
        m_tdata_next[0]   = level_next;
        m_tdata_next[1]   = level_next != level_reg;
        m_tdata_next[2]   = accepted;
        m_tdata_next[3]   = q_level_next >= CNT_FULL;
        m_tdata_next[6:4] = LEVEL_W'(q_level_next);
        m_tdata_next[7]   = cyc_next != '0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_reg    <= '0;
            cd_reg     <= '0;
            level_reg  <= 1'b0;
            run_en_reg <= 1'b0;
        end
        else
        begin
            cyc_reg    <= cyc_next;
            cd_reg     <= cd_next;
            level_reg  <= level_next;
            run_en_reg <= run_en_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ design/ffbpg_checker.sv @@
// ----------------------------------------------------------------------------
// ffbpg_checker
// Port-level checks on the burst pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fifo_fed_burst_pulse_generator_defines.svh"

module ffbpg_checker #(
    parameter int QUEUE_DEPTH = 4
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ffbpg_pkg::M_DATA_W-1:0]  m_tdata
);
    import ffbpg_pkg::*;

    // Stalled status word holds
    `FFBPG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "status word changed while stalled")

    // Empty output slot never blocks the request stream
    `FFBPG_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "request stream blocked with empty output")

    // Pin only sits high inside a burst
    `FFBPG_ASSERT_NOW(a_high_in_burst, m_tvalid && m_tdata[0], m_tdata[7], "pin high with no burst running")

    // Full flag agrees with the reported level
    `FFBPG_ASSERT_NOW(a_full_level, m_tvalid && m_tdata[3], m_tdata[6:4] == LEVEL_W'(QUEUE_DEPTH), "full flag with wrong fill level")

endmodule

bind fifo_fed_burst_pulse_generator ffbpg_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ffbpg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
